// ===== design/nsc_pkg.sv =====
// Shared types, character codes and helper functions of the NMEA sentence checker.
`default_nettype none

package nsc_pkg;

    localparam int unsigned NSC_MAX_FIELDS_DEF = 32;
    localparam int unsigned NSC_TYPE_W         = 24;
    localparam int unsigned NSC_FIELD_W        = 5;
    localparam logic [NSC_TYPE_W-1:0] NSC_TYPE_RESET = 24'h434843;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_NO_STAR   = 2'd1,
        VERDICT_BAD_SUM   = 2'd2,
        VERDICT_BAD_TYPE  = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_SUM  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } nsc_item_t;

    typedef struct packed {
        logic                   data_valid;
        logic [7:0]             data_byte;
        logic [NSC_FIELD_W-1:0] field_index;
        logic                   field_end;
        logic                   done_res;
        verdict_t               verdict;
    } nsc_result_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
        begin
            d = CH_ZERO + {4'd0, v};
        end
        else
        begin
            d = CH_UPPER_A + {4'd0, v} - 8'd10;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/nsc_input_reg.sv =====
// Input register stage holding one accepted word until the sentence core takes it.
`default_nettype none

module nsc_input_reg
    import nsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire nsc_item_t in_item,
    input  wire logic      step,
    output logic           item_valid,
    output nsc_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    nsc_item_t item_reg;

    assign in_ready   = !valid_reg || step;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/nsc_core.sv =====
// Sentence state, checksum, type match and field counting for one character per cycle while step is high.
`default_nettype none

module nsc_core
    import nsc_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = NSC_MAX_FIELDS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [NSC_TYPE_W-1:0] cfg_wr_data,
    input  wire nsc_item_t             item,
    input  wire logic                  step,
    output logic                       has_result,
    output nsc_result_t                result
);

    localparam int unsigned FIELD_TOP_I = (MAX_FIELDS - 1 < 31) ? MAX_FIELDS - 1 : 31;
    localparam logic [NSC_FIELD_W-1:0] FIELD_TOP = NSC_FIELD_W'(FIELD_TOP_I);

    logic [NSC_TYPE_W-1:0]  type_reg;
    phase_t                 phase_reg,   phase_next;
    logic [7:0]             sum_reg,     sum_next;
    logic [2:0]             pos_reg,     pos_next;
    logic                   type_ok_reg, type_ok_next;
    logic [NSC_FIELD_W-1:0] fcount_reg,  fcount_next;
    logic [15:0]            hex_reg,     hex_next;
    logic [1:0]             hcount_reg,  hcount_next;

    logic       kept;
    logic [7:0] b;
    logic [7:0] want;
    logic [7:0] sum_upd;
    phase_t     phase_upd;
    logic [15:0] hex_upd;
    logic [1:0] hcount_upd;
    logic [2:0] pos_upd;
    logic       type_ok_upd;
    logic [NSC_FIELD_W-1:0] fcount_upd;
    logic [15:0] expect_sum;

    assign b    = item.byte_in;
    assign kept = (b != CH_SPACE) && (b != CH_PLUS);
    assign has_result = kept || item.last_byte;

    always_comb
    begin
        unique case (pos_reg)
            3'd3:    want = type_reg[23:16];
            3'd4:    want = type_reg[15:8];
            default: want = type_reg[7:0];
        endcase
    end

    // Per-character state update, before the end-of-sentence clear.
    always_comb
    begin
        phase_upd   = phase_reg;
        sum_upd     = sum_reg;
        pos_upd     = pos_reg;
        type_ok_upd = type_ok_reg;
        fcount_upd  = fcount_reg;
        hex_upd     = hex_reg;
        hcount_upd  = hcount_reg;
        if (kept)
        begin
            if (pos_reg >= 3'd3 && pos_reg <= 3'd5 && want != b)
            begin
                type_ok_upd = 1'b0;
            end
            if (pos_reg < 3'd6)
            begin
                pos_upd = pos_reg + 3'd1;
            end
            if (phase_reg != PH_HEAD && phase_reg != PH_BODY)
            begin
                if (hcount_reg < 2'd2)
                begin
                    hex_upd    = {hex_reg[7:0], b};
                    hcount_upd = hcount_reg + 2'd1;
                end
            end
            else if (b == CH_STAR)
            begin
                phase_upd = PH_SUM;
            end
            else if (b == CH_DOLLAR && phase_reg == PH_HEAD)
            begin
                sum_upd   = 8'd0;
                phase_upd = PH_BODY;
            end
            else
            begin
                sum_upd = sum_reg ^ b;
            end
            if (b == CH_COMMA && fcount_reg < FIELD_TOP)
            begin
                fcount_upd = fcount_reg + NSC_FIELD_W'(1);
            end
        end
    end

    assign expect_sum = {hex_digit(sum_upd[7:4]), hex_digit(sum_upd[3:0])};

    always_comb
    begin
        result.data_valid  = kept && (b != CH_COMMA);
        result.data_byte   = (kept && (b != CH_COMMA)) ? b : 8'd0;
        result.field_index = fcount_reg;
        result.field_end   = (kept && (b == CH_COMMA)) || item.last_byte;
        result.done_res    = item.last_byte;
        result.verdict     = VERDICT_OK;
        if (item.last_byte)
        begin
            priority if (phase_upd == PH_HEAD || phase_upd == PH_BODY)
            begin
                result.verdict = VERDICT_NO_STAR;
            end
            else if (hcount_upd < 2'd2 || hex_upd != expect_sum)
            begin
                result.verdict = VERDICT_BAD_SUM;
            end
            else if (pos_upd < 3'd6 || !type_ok_upd)
            begin
                result.verdict = VERDICT_BAD_TYPE;
            end
            else
            begin
                result.verdict = VERDICT_OK;
            end
        end
    end

    always_comb
    begin
        if (item.last_byte)
        begin
            phase_next   = PH_HEAD;
            sum_next     = 8'd0;
            pos_next     = 3'd0;
            type_ok_next = 1'b1;
            fcount_next  = '0;
            hex_next     = 16'd0;
            hcount_next  = 2'd0;
        end
        else
        begin
            phase_next   = phase_upd;
            sum_next     = sum_upd;
            pos_next     = pos_upd;
            type_ok_next = type_ok_upd;
            fcount_next  = fcount_upd;
            hex_next     = hex_upd;
            hcount_next  = hcount_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg    <= NSC_TYPE_RESET;
            phase_reg   <= PH_HEAD;
            sum_reg     <= 8'd0;
            pos_reg     <= 3'd0;
            type_ok_reg <= 1'b1;
            fcount_reg  <= '0;
            hex_reg     <= 16'd0;
            hcount_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                type_reg <= cfg_wr_data;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                sum_reg     <= sum_next;
                pos_reg     <= pos_next;
                type_ok_reg <= type_ok_next;
                fcount_reg  <= fcount_next;
                hex_reg     <= hex_next;
                hcount_reg  <= hcount_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/nsc_output_reg.sv =====
// Result register that holds one finished word until the consumer takes it.
`default_nettype none

module nsc_output_reg
    import nsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire nsc_result_t load_data,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic             can_load,
    output nsc_result_t      data
);

    logic        valid_reg;
    logic        valid_next;
    nsc_result_t data_reg;

    assign out_valid = valid_reg;
    assign can_load  = !valid_reg || out_ready;
    assign data      = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker: input register, sentence core, result register.
// A word accepted into the input register is loaded into the result register when it steps through the core.
// Throughput: one word per cycle while the result register can take it, set by the state update in the core.
// Dropped characters (space, plus) that are not the last byte step through the core but give no result.
// Reset (rst_n low, asynchronous) empties both registers and restores the sentence
// type to "CHC"; no clearing pass follows, so the block is ready at once.
`default_nettype none

module nmea_sentence_checker
    import nsc_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = NSC_MAX_FIELDS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Character input channel.
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             byte_in,
    input  wire logic                   last_byte,

    // Result channel.
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        data_valid,
    output logic [7:0]                  data_byte,
    output logic [NSC_FIELD_W-1:0]      field_index,
    output logic                        field_end,
    output logic                        done_res,
    output logic [1:0]                  verdict,

    // Sentence type register write port.
    input  wire logic                   cfg_wr_en,
    input  wire logic [NSC_TYPE_W-1:0]  cfg_wr_data
);

    nsc_item_t   in_item;
    nsc_item_t   item;
    logic        item_valid;
    logic        step;
    logic        has_result;
    logic        can_load;
    nsc_result_t core_result;
    nsc_result_t out_result;

    assign in_item.byte_in   = byte_in;
    assign in_item.last_byte = last_byte;

    // The held character moves through the core when its result has a place to go,
    // or when it produces no result at all. The sentence state advances at that edge.
    assign step = item_valid && (can_load || !has_result);

    nsc_input_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    nsc_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .step        (step),
        .has_result  (has_result),
        .result      (core_result)
    );

    // The result register loads whenever a stepping character yields a word.
    nsc_output_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && has_result),
        .load_data (core_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .data      (out_result)
    );

    assign data_valid  = out_result.data_valid;
    assign data_byte   = out_result.data_byte;
    assign field_index = out_result.field_index;
    assign field_end   = out_result.field_end;
    assign done_res    = out_result.done_res;
    assign verdict     = out_result.verdict;

endmodule

`default_nettype wire

// ===== design/nsc_checker.sv =====
// Port-level assertions for the NMEA sentence checker and the bind that attaches them.
`default_nettype none

module nsc_checker
    import nsc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   data_valid,
    input wire logic [7:0]             data_byte,
    input wire logic [NSC_FIELD_W-1:0] field_index,
    input wire logic                   field_end,
    input wire logic                   done_res,
    input wire logic [1:0]             verdict
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(verdict)
            && $stable(field_index) && $stable(done_res))
        else $error("result word changed while stalled");

    a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> verdict == VERDICT_OK)
        else $error("verdict set on a word that does not end the sentence");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> data_byte == 8'd0 && field_end)
        else $error("word without data is neither a comma nor a sentence end");

    a_end_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> field_end)
        else $error("sentence end does not close a field");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_valid  (data_valid),
    .data_byte   (data_byte),
    .field_index (field_index),
    .field_end   (field_end),
    .done_res    (done_res),
    .verdict     (verdict)
);

`default_nettype wire

// ===== dv/nsc_tb_pkg.sv =====
// Scoreboard class and character helpers for the NMEA sentence checker testbench.
package nsc_tb_pkg;

    import nsc_pkg::*;

    localparam int unsigned FIELD_TOP =
        (NSC_MAX_FIELDS_DEF - 1 < 31) ? NSC_MAX_FIELDS_DEF - 1 : 31;

    function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UPPER_A + 8'(n - 4'd10);
    endfunction

    class sentence_scoreboard;

        logic [NSC_TYPE_W-1:0]  type_reg;
        phase_t                 phase;
        logic [7:0]             running_xor;
        int unsigned            kept_pos;
        bit                     type_match;
        logic [NSC_FIELD_W-1:0] comma_count;
        logic [15:0]            sum_chars;
        int unsigned            sum_char_count;

        nsc_result_t            awaited_words[$];
        int unsigned            failures;
        int unsigned            words_checked;
        int unsigned            verdict_tally[4];

        function new();
            type_reg = NSC_TYPE_RESET;
            failures = 0;
            words_checked = 0;
            foreach (verdict_tally[i])
                verdict_tally[i] = 0;
            clear_sentence();
        endfunction

        function void clear_sentence();
            phase = PH_HEAD;
            running_xor = 8'h00;
            kept_pos = 0;
            type_match = 1'b1;
            comma_count = '0;
            sum_chars = 16'h0000;
            sum_char_count = 0;
        endfunction

        // Advances the sentence state by one accepted character and queues the
        // word it produces, if any.
        function void note_char(input logic [7:0] ch, input logic last);
            nsc_result_t w;
            logic        kept;
            logic [15:0] good_sum;
            kept = (ch != CH_SPACE) && (ch != CH_PLUS);
            w = '0;
            w.field_index = comma_count;
            w.verdict = VERDICT_OK;
            if (kept)
            begin
                if (kept_pos >= 3 && kept_pos <= 5)
                begin
                    if (type_reg[8*(5-kept_pos) +: 8] != ch)
                        type_match = 1'b0;
                end
                if (kept_pos < 6)
                    kept_pos++;
                if (phase == PH_SUM)
                begin
                    if (sum_char_count < 2)
                    begin
                        sum_chars = {sum_chars[7:0], ch};
                        sum_char_count++;
                    end
                end
                else if (ch == CH_STAR)
                    phase = PH_SUM;
                else if (ch == CH_DOLLAR && phase == PH_HEAD)
                begin
                    running_xor = 8'h00;
                    phase = PH_BODY;
                end
                else
                    running_xor ^= ch;
                if (ch == CH_COMMA)
                begin
                    w.field_end = 1'b1;
                    if (comma_count < FIELD_TOP)
                        comma_count++;
                end
                else
                begin
                    w.data_valid = 1'b1;
                    w.data_byte = ch;
                end
            end
            if (last)
            begin
                w.field_end = 1'b1;
                w.done_res = 1'b1;
                good_sum = {nibble_ascii(running_xor[7:4]), nibble_ascii(running_xor[3:0])};
                if (phase != PH_SUM)
                    w.verdict = VERDICT_NO_STAR;
                else if (sum_char_count < 2 || sum_chars != good_sum)
                    w.verdict = VERDICT_BAD_SUM;
                else if (kept_pos < 6 || !type_match)
                    w.verdict = VERDICT_BAD_TYPE;
                verdict_tally[w.verdict]++;
                clear_sentence();
            end
            if (kept || last)
                awaited_words = {awaited_words, w};
        endfunction

        function void check_word(input nsc_result_t got);
            nsc_result_t exp;
            if (awaited_words.size() == 0)
            begin
                $error("result word arrived with no expected word pending");
                failures++;
                return;
            end
            exp = awaited_words.pop_front();
            words_checked++;
            if (got.data_valid != exp.data_valid)
            begin
                $error("data_valid: expected %0d, actual %0d", exp.data_valid, got.data_valid);
                failures++;
            end
            if (got.data_byte != exp.data_byte)
            begin
                $error("data_byte: expected 0x%02h, actual 0x%02h", exp.data_byte, got.data_byte);
                failures++;
            end
            if (got.field_index != exp.field_index)
            begin
                $error("field_index: expected %0d, actual %0d",
                       exp.field_index, got.field_index);
                failures++;
            end
            if (got.field_end != exp.field_end)
            begin
                $error("field_end: expected %0d, actual %0d", exp.field_end, got.field_end);
                failures++;
            end
            if (got.done_res != exp.done_res)
            begin
                $error("done_res: expected %0d, actual %0d", exp.done_res, got.done_res);
                failures++;
            end
            if (got.verdict != exp.verdict)
            begin
                $error("verdict: expected %0d, actual %0d", exp.verdict, got.verdict);
                failures++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench of the NMEA sentence checker: stimulus, handshakes and final verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;
    import nsc_tb_pkg::*;

    localparam int unsigned CHAR_GOAL   = 550;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             byte_in = 8'h00;
    logic                   last_byte = 1'b0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   data_valid;
    logic [7:0]             data_byte;
    logic [NSC_FIELD_W-1:0] field_index;
    logic                   field_end;
    logic                   done_res;
    logic [1:0]             verdict;

    logic                   cfg_wr_en = 1'b0;
    logic [NSC_TYPE_W-1:0]  cfg_wr_data = '0;

    sentence_scoreboard sb;
    nsc_result_t        seen_word;
    logic [7:0]         line_q[$];
    int unsigned        chars_sent = 0;
    int unsigned        sentences_sent = 0;
    int unsigned        type_settings = 1;
    int unsigned        cycle_count = 0;
    bit                 in_calm = 1'b0;
    bit                 out_calm = 1'b0;

    nmea_sentence_checker uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_valid  (data_valid),
        .data_byte   (data_byte),
        .field_index (field_index),
        .field_end   (field_end),
        .done_res    (done_res),
        .verdict     (verdict),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both channels are observed at the rising edge, where the sampled values are
    // the ones that settled during the previous cycle. An accepted character is
    // fed to the scoreboard before any word from the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_char(byte_in, last_byte);
        if (rst_n && out_valid && out_ready)
        begin
            seen_word.data_valid  = data_valid;
            seen_word.data_byte   = data_byte;
            seen_word.field_index = field_index;
            seen_word.field_end   = field_end;
            seen_word.done_res    = done_res;
            seen_word.verdict     = verdict_t'(verdict);
            sb.check_word(seen_word);
        end
    end

    // The receiver draws a stall before every word. Calm stretches, where the
    // stall is always zero, come and go at random so that back-to-back traffic
    // is exercised as well.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog: the run is declared broken if it outlasts the cycle budget.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Presents one character and returns at the edge where it is accepted. When
    // no gap is drawn, valid simply stays high into the next word.
    task automatic send_char(input logic [7:0] ch, input logic last);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        byte_in   <= ch;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
    endtask

    // Sends the buffered sentence, marking its final character as the last byte.
    task automatic send_line();
        foreach (line_q[i])
            send_char(line_q[i], i == line_q.size() - 1);
        line_q.delete();
        sentences_sent++;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q = {line_q, s[i]};
    endfunction

    // Occasionally slips a space or a plus in front of the character; the block
    // must drop these without touching the checksum or the position count.
    function automatic void push_kept(input logic [7:0] c);
        if ($urandom_range(0, 11) == 0)
            line_q = {line_q, ($urandom_range(0, 1) ? CH_SPACE : CH_PLUS)};
        line_q = {line_q, c};
    endfunction

    // Checksum of the buffered sentence as a well-behaved talker would compute
    // it: kept characters after the first dollar sign, up to the star.
    function automatic logic [7:0] line_xor();
        logic [7:0] x;
        bit         seen_dollar;
        x = 8'h00;
        seen_dollar = 1'b0;
        foreach (line_q[i])
        begin
            if (line_q[i] == CH_SPACE || line_q[i] == CH_PLUS)
                continue;
            if (line_q[i] == CH_STAR)
                break;
            if (line_q[i] == CH_DOLLAR && !seen_dollar)
            begin
                x = 8'h00;
                seen_dollar = 1'b1;
            end
            else
                x ^= line_q[i];
        end
        return x;
    endfunction

    function automatic void add_sum(input logic [7:0] x);
        line_q = {line_q, nibble_ascii(x[7:4])};
        line_q = {line_q, nibble_ascii(x[3:0])};
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 7) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(8'h21, 8'h7E));
        end
        while (c == CH_STAR || c == CH_COMMA);
        return c;
    endfunction

    // Builds a sentence with a talker, a type, a few fields and a checksum.
    // Most come out valid; the rest carry a lowercase, short or wrong checksum,
    // a foreign type, a missing dollar sign or many fields to saturate the index.
    function automatic void build_sentence(input logic [NSC_TYPE_W-1:0] kind);
        logic [7:0]  sum;
        int unsigned nf;
        int unsigned flen;
        int unsigned style;
        if ($urandom_range(0, 9) != 0)
            push_kept(CH_DOLLAR);
        repeat (2) push_kept(8'($urandom_range(8'h41, 8'h5A)));
        if ($urandom_range(0, 6) != 0)
        begin
            push_kept(kind[23:16]);
            push_kept(kind[15:8]);
            push_kept(kind[7:0]);
        end
        else
            repeat (3) push_kept(8'($urandom_range(8'h41, 8'h5A)));
        nf = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        repeat (nf)
        begin
            push_kept(CH_COMMA);
            flen = (nf > 20) ? $urandom_range(0, 1) : $urandom_range(0, 6);
            repeat (flen) push_kept(body_char());
        end
        sum = line_xor();
        push_kept(CH_STAR);
        style = $urandom_range(0, 9);
        case (style)
            0:
            begin
                push_kept(nibble_ascii(sum[7:4]) | 8'h20);
                push_kept(nibble_ascii(sum[3:0]) | 8'h20);
            end
            1: push_kept(nibble_ascii(sum[7:4]));
            2: ;
            3: add_sum(sum ^ 8'($urandom_range(1, 255)));
            default:
            begin
                push_kept(nibble_ascii(sum[7:4]));
                push_kept(nibble_ascii(sum[3:0]));
            end
        endcase
        if ($urandom_range(0, 1) != 0)
        begin
            line_q = {line_q, 8'h0D};
            line_q = {line_q, 8'h0A};
        end
    endfunction

    // Waits until every expected word has come back, then lets the two-stage
    // pipeline run dry before the register may be touched again.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_type(input logic [NSC_TYPE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.type_reg = v;
        type_settings++;
    endtask

    initial
    begin
        logic [NSC_TYPE_W-1:0] plan[PHASES];
        int unsigned           goal;
        int unsigned           k;
        int unsigned           pick;

        sb = new();
        plan[0] = NSC_TYPE_RESET;
        plan[1] = 24'h000000;
        plan[2] = 24'hFFFFFF;
        plan[3] = "GGA";
        plan[4] = 24'($urandom_range(0, 24'hFFFFFF));
        plan[5] = NSC_TYPE_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sentences under the reset type. Single characters at the byte
        // extremes end without a star; a lone space or plus as the last byte
        // still closes the sentence with an empty word.
        line_q = {line_q, 8'h00};
        send_line();
        line_q = {line_q, 8'hFF};
        send_line();
        line_q = {line_q, CH_SPACE};
        send_line();
        line_q = {line_q, CH_PLUS};
        send_line();
        // A bare star leaves both checksum digits missing.
        line_q = {line_q, CH_STAR};
        send_line();
        // A dollar sign after the star is taken as a checksum digit, and one
        // digit alone is still a checksum failure.
        add_text("$*$");
        send_line();
        // A good sentence with an empty first field and a second dollar sign
        // inside the body, which is summed like any other character.
        add_text("$,$CHC*");
        add_sum(line_xor());
        send_line();
        // No dollar sign, so the sum runs from the first character; the type
        // characters do not match.
        add_text("ABCXYZ*");
        add_sum(line_xor());
        send_line();
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                write_type(plan[p]);
            goal = (CHAR_GOAL * (p + 1)) / PHASES;
            while (chars_sent < goal)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 5)
                begin
                    // Noise: arbitrary bytes of arbitrary length.
                    k = $urandom_range(1, 12);
                    repeat (k) line_q = {line_q, 8'($urandom_range(0, 255))};
                end
                else
                begin
                    build_sentence(plan[p]);
                    // A cut-off sentence ends early at a random point.
                    if (pick < 8)
                    begin
                        k = $urandom_range(1, line_q.size());
                        while (line_q.size() > k)
                            void'(line_q.pop_back());
                    end
                end
                send_line();
            end
            wait_idle();
        end

        $display("Sent %0d characters in %0d sentences, %0d type settings, %0d words checked.",
                 chars_sent, sentences_sent, type_settings, sb.words_checked);
        $display("Verdicts: %0d ok, %0d no star, %0d bad checksum, %0d bad type.",
                 sb.verdict_tally[VERDICT_OK], sb.verdict_tally[VERDICT_NO_STAR],
                 sb.verdict_tally[VERDICT_BAD_SUM], sb.verdict_tally[VERDICT_BAD_TYPE]);
        if (sb.failures == 0 && sb.awaited_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== nmea_sentence_checker.f =====
design/nsc_pkg.sv
design/nsc_input_reg.sv
design/nsc_core.sv
design/nsc_output_reg.sv
design/nmea_sentence_checker.sv
design/nsc_checker.sv
dv/nsc_tb_pkg.sv
dv/tb_top.sv
